FILE: design/sals_pkg.sv
// shared types and constants of the scan arc length subsampler
package sals_pkg;

  // scan size limit and derived widths
  localparam int unsigned MaxPoints = 2048;
  localparam int unsigned CntW      = $clog2(MaxPoints);

  // fixed field widths
  localparam int unsigned RangeW   = 16;
  localparam int unsigned IdxW     = 11;
  localparam int unsigned CosW     = 18;
  localparam int unsigned SpacingW = 24;
  localparam int unsigned PathW    = 32;
  localparam int unsigned CfgDataW = 24;

  // arithmetic widths
  localparam int unsigned ProdW  = 50;  // signed product of the shared multiplier
  localparam int unsigned SqSumW = 33;  // a^2 + b^2
  localparam int unsigned C2W    = 52;  // signed chord squared in Q.16
  localparam int unsigned RadW   = 34;  // integer chord squared
  localparam int unsigned RootW  = 17;  // chord length
  localparam int unsigned RemW   = 18;  // square root remainder
  localparam int unsigned IterW  = 5;

  // cosine limits in Q2.16
  localparam logic signed [CosW-1:0] CosOne    = 18'sd65536;
  localparam logic signed [CosW-1:0] CosMinOne = -18'sd65536;

  // register reset values
  localparam logic [SpacingW-1:0] SpacingReset = 24'd1000;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_COS_STEP      = 1'b0,
    CFG_BREAK_SPACING = 1'b1
  } cfg_idx_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_COMB,
    ST_SQRT,
    ST_UPDATE
  } state_e;

endpackage

FILE: design/scan_arc_length_subsampler_core.sv
// scan arc length subsampler: chord by law of cosines, path sum and break indexes
//
//  channel  | handshake             | payload
//  ---------+-----------------------+----------------------------------
//  in       | in_valid_i/in_ready_o | range_mm_i[15:0], scan_start_i
//  out      | out_valid_o/out_ready_i | break_index_o[10:0]
//  cfg      | cfg_we_i              | cfg_idx_i, cfg_wdata_i[23:0]
//
// an ordinary sample keeps the block busy after its transfer for 4 passes of
// the shared multiplier, 1 combine, 17 steps of the bit-serial square root
// and 1 update, and no new sample is taken until the block is idle again
// scan start and samples past the scan limit do not leave the idle state
// the update waits only while a previous result is still held at the output and the sample would emit a break
// asynchronous active-low reset clears control state and the path registers
module scan_arc_length_subsampler_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [sals_pkg::RangeW-1:0]        range_mm_i,
  input  logic                               scan_start_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [sals_pkg::IdxW-1:0]          break_index_o,
  input  logic                               cfg_we_i,
  input  logic                               cfg_idx_i,
  input  logic [sals_pkg::CfgDataW-1:0]      cfg_wdata_i
);

  sals_pkg::state_e state_q, state_d;

  // configuration
  logic signed [sals_pkg::CosW-1:0]  cos_step_q;
  logic [sals_pkg::SpacingW-1:0]     break_spacing_q;

  // scan state
  logic [sals_pkg::RangeW-1:0]       prev_range_q;
  logic [sals_pkg::CntW-1:0]         sample_count_q;
  logic [sals_pkg::PathW-1:0]        path_length_q;
  logic [sals_pkg::PathW-1:0]        next_break_q;

  // datapath
  logic [sals_pkg::RangeW-1:0]       a_q, b_q;
  logic [1:0]                        mul_step_q;
  logic signed [sals_pkg::ProdW-1:0] prod_q;
  logic [sals_pkg::SqSumW-1:0]       sq_sum_q;
  logic [sals_pkg::RadW-1:0]         rad_q;
  logic [sals_pkg::RemW-1:0]         rem_q;
  logic [sals_pkg::RootW-1:0]        root_q;
  logic [sals_pkg::IterW-1:0]        iter_q;

  // output register
  logic                              out_valid_q;
  logic [sals_pkg::IdxW-1:0]         out_idx_q;

  logic in_xfer, out_xfer, at_limit, emit, out_blocked, upd_go;

  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_xfer    = out_valid_q && out_ready_i;
  assign at_limit    = sample_count_q >= sals_pkg::CntW'(sals_pkg::MaxPoints - 1);
  assign out_blocked = out_valid_q && !out_ready_i;

  // cosine clamped to [-1, 1]
  logic signed [sals_pkg::CosW-1:0] cos_clamped;
  always_comb begin
    priority if (cos_step_q > sals_pkg::CosOne) begin
      cos_clamped = sals_pkg::CosOne;
    end else if (cos_step_q < sals_pkg::CosMinOne) begin
      cos_clamped = sals_pkg::CosMinOne;
    end else begin
      cos_clamped = cos_step_q;
    end
  end

  // shared multiplier operand select: a*a, b*b, a*b, ab*cos
  logic [31:0]                      mul_x;
  logic signed [sals_pkg::CosW-1:0] mul_y;
  logic signed [50:0]               mul_p;
  always_comb begin
    unique case (mul_step_q)
      2'd0: begin
        mul_x = 32'(a_q);
        mul_y = $signed({2'b00, a_q});
      end
      2'd1: begin
        mul_x = 32'(b_q);
        mul_y = $signed({2'b00, b_q});
      end
      2'd2: begin
        mul_x = 32'(a_q);
        mul_y = $signed({2'b00, b_q});
      end
      default: begin
        mul_x = prod_q[31:0];
        mul_y = cos_clamped;
      end
    endcase
  end
  assign mul_p = $signed({1'b0, mul_x}) * mul_y;

  // chord squared: (a^2 + b^2) * 2^16 - 2*a*b*cos, floored to an integer, negative clamped to zero
  logic signed [sals_pkg::C2W-1:0] c2;
  logic [sals_pkg::RadW-1:0]       rad_d;
  assign c2 = $signed({3'b000, sq_sum_q, 16'h0000}) - $signed({prod_q[49], prod_q, 1'b0});
  assign rad_d = c2[sals_pkg::C2W-1] ? '0 : c2[49:16];

  // one restoring square root step
  logic [19:0] rem_sh, trial, rem_diff;
  logic        take;
  assign rem_sh   = {rem_q, rad_q[sals_pkg::RadW-1 -: 2]};
  assign trial    = {1'b0, root_q, 2'b01};
  assign take     = rem_sh >= trial;
  assign rem_diff = rem_sh - trial;

  // saturating path and break updates
  logic [sals_pkg::PathW:0]   path_sum, break_sum;
  logic [sals_pkg::PathW-1:0] path_new, break_new;
  assign path_sum  = {1'b0, path_length_q} + (sals_pkg::PathW + 1)'(root_q);
  assign path_new  = path_sum[sals_pkg::PathW] ? '1 : path_sum[sals_pkg::PathW-1:0];
  assign break_sum = {1'b0, next_break_q} + (sals_pkg::PathW + 1)'(break_spacing_q);
  assign break_new = break_sum[sals_pkg::PathW] ? '1 : break_sum[sals_pkg::PathW-1:0];
  assign emit      = path_new > next_break_q;
  assign upd_go    = !(emit && out_blocked);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sals_pkg::ST_IDLE: begin
        if (in_xfer && !scan_start_i && !at_limit) begin
          state_d = sals_pkg::ST_MUL;
        end
      end
      sals_pkg::ST_MUL: begin
        if (mul_step_q == 2'd3) begin
          state_d = sals_pkg::ST_COMB;
        end
      end
      sals_pkg::ST_COMB: begin
        state_d = sals_pkg::ST_SQRT;
      end
      sals_pkg::ST_SQRT: begin
        if (iter_q == sals_pkg::IterW'(sals_pkg::RootW - 1)) begin
          state_d = sals_pkg::ST_UPDATE;
        end
      end
      sals_pkg::ST_UPDATE: begin
        if (upd_go) begin
          state_d = sals_pkg::ST_IDLE;
        end
      end
      default: state_d = sals_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o    = state_q == sals_pkg::ST_IDLE;
    out_valid_o   = out_valid_q;
    break_index_o = out_idx_q;
  end

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sals_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_step_q      <= sals_pkg::CosOne;
      break_spacing_q <= sals_pkg::SpacingReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sals_pkg::CFG_COS_STEP:      cos_step_q      <= $signed(cfg_wdata_i[sals_pkg::CosW-1:0]);
        sals_pkg::CFG_BREAK_SPACING: break_spacing_q <= cfg_wdata_i[sals_pkg::SpacingW-1:0];
        default: ;
      endcase
    end
  end

  // scan state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_range_q   <= '0;
      sample_count_q <= '0;
      path_length_q  <= '0;
      next_break_q   <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
      if (in_xfer) begin
        if (scan_start_i) begin
          prev_range_q   <= range_mm_i;
          sample_count_q <= '0;
          path_length_q  <= '0;
          next_break_q   <= 32'(break_spacing_q);
        end else if (!at_limit) begin
          prev_range_q   <= range_mm_i;
          sample_count_q <= sample_count_q + 1'b1;
        end
      end
      if (state_q == sals_pkg::ST_UPDATE && upd_go) begin
        path_length_q <= path_new;
        if (emit) begin
          next_break_q <= break_new;
          out_valid_q  <= 1'b1;
        end
      end
    end
  end

  // result index
  always_ff @(posedge clk_i) begin
    if (state_q == sals_pkg::ST_UPDATE && upd_go && emit) begin
      out_idx_q <= sals_pkg::IdxW'(sample_count_q);
    end
  end

  // multiplier pass and square root iteration counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_step_q <= '0;
      iter_q     <= '0;
    end else begin
      unique case (state_q)
        sals_pkg::ST_MUL:  mul_step_q <= mul_step_q + 1'b1;
        sals_pkg::ST_SQRT: iter_q     <= iter_q + 1'b1;
        default: begin
          mul_step_q <= '0;
          iter_q     <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      sals_pkg::ST_IDLE: begin
        a_q <= prev_range_q;
        b_q <= range_mm_i;
      end
      sals_pkg::ST_MUL: begin
        prod_q <= mul_p[sals_pkg::ProdW-1:0];
        if (mul_step_q == 2'd1) begin
          sq_sum_q <= sals_pkg::SqSumW'(prod_q[31:0]);
        end else if (mul_step_q == 2'd2) begin
          sq_sum_q <= sq_sum_q + sals_pkg::SqSumW'(prod_q[31:0]);
        end
      end
      sals_pkg::ST_COMB: begin
        rad_q  <= rad_d;
        rem_q  <= '0;
        root_q <= '0;
      end
      sals_pkg::ST_SQRT: begin
        rad_q <= {rad_q[sals_pkg::RadW-3:0], 2'b00};
        if (take) begin
          rem_q  <= rem_diff[sals_pkg::RemW-1:0];
          root_q <= {root_q[sals_pkg::RootW-2:0], 1'b1};
        end else begin
          rem_q  <= rem_sh[sals_pkg::RemW-1:0];
          root_q <= {root_q[sals_pkg::RootW-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: design/sals_checker.sv
// port checker for the scan arc length subsampler, bound to the top level
module sals_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        scan_start_i,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [sals_pkg::IdxW-1:0]   break_index_o
);

  // a held result stays put until its transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(break_index_o))
    else $error("held result changed before transfer");

  // the block is ready again in the cycle after a scan start
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && scan_start_i |=> in_ready_o)
    else $error("busy after scan start");

  // a new result only comes out of a sample under work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared while idle");

  // the first sample of a scan never carries a break
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> break_index_o != '0)
    else $error("break at sample index zero");

endmodule

bind scan_arc_length_subsampler_core sals_checker u_sals_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .scan_start_i  (scan_start_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .break_index_o (break_index_o)
);
